// File: rtl/mcbd_pkg.sv
// Shared types, command and result codes, and default sizes for the
// per-class bounded deque bank. No dependencies.
package mcbd_pkg;

	// Default sizes handed to the top level
	localparam int NUM_QUEUES_DEF = 16;
	localparam int DEPTH_DEF      = 8;
	localparam int TAG_BITS_DEF   = 16;

	// Command codes (bit 1 alone selects a take)
	localparam logic [1:0] CMD_ADD_TAIL = 2'd0;
	localparam logic [1:0] CMD_ADD_HEAD = 2'd1;
	localparam logic [1:0] CMD_TAKE     = 2'd2;

	// Result codes
	localparam logic [1:0] RES_ADDED    = 2'd0;
	localparam logic [1:0] RES_FULL     = 2'd1;
	localparam logic [1:0] RES_TAKEN    = 2'd2;
	localparam logic [1:0] RES_EMPTY    = 2'd3;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CTRL,
		ST_ENTRY
	} mcbd_state_t;

endpackage

// File: rtl/mcbd_ctrl_mem.sv
// Per-queue control memory: ring head slot and fill count for each queue.
// Registered synchronous read; valid bits make never-written queues read as empty.
// Uses no package items.
module mcbd_ctrl_mem #(
	parameter int NUM_QUEUES = 16,
	parameter int DEPTH      = 8,
	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
	localparam int PW = $clog2(DEPTH),
	localparam int FW = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [QW-1:0] rd_addr,
	output logic [PW-1:0] rd_head,
	output logic [FW-1:0] rd_fill,
	input  logic          wr_en,
	input  logic [QW-1:0] wr_addr,
	input  logic [PW-1:0] wr_head,
	input  logic [FW-1:0] wr_fill
);

	logic [PW+FW-1:0]     mem [NUM_QUEUES];
	logic [NUM_QUEUES-1:0] valid_q;
	logic [PW+FW-1:0]     rd_data_q;
	logic                 rd_valid_q;

	// Storage array, written and read in one clocked block
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_head, wr_fill};
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Written-once marks stand in for the all-zero reset of the array
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	// Unwritten queue reads as head 0, fill 0
	assign rd_head = rd_valid_q ? rd_data_q[PW+FW-1:FW] : '0;
	assign rd_fill = rd_valid_q ? rd_data_q[FW-1:0]     : '0;

endmodule

// File: rtl/mcbd_entry_mem.sv
// Entry memory: tag and urgent flag for every ring slot of every queue.
// One write and one read port, read data registered. Uses no package items.
module mcbd_entry_mem #(
	parameter int NUM_QUEUES = 16,
	parameter int DEPTH      = 8,
	parameter int TAG_BITS   = 16,
	localparam int AW = (NUM_QUEUES * DEPTH > 1) ? $clog2(NUM_QUEUES * DEPTH) : 1
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  logic [TAG_BITS-1:0] wr_tag,
	input  logic                wr_urgent,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output logic [TAG_BITS-1:0] rd_tag,
	output logic                rd_urgent
);

	logic [TAG_BITS:0] mem [NUM_QUEUES * DEPTH];
	logic [TAG_BITS:0] rd_data_q;

	// Slot storage; only occupied slots are ever read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_urgent, wr_tag};
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_urgent = rd_data_q[TAG_BITS];
	assign rd_tag    = rd_data_q[TAG_BITS-1:0];

endmodule

// File: rtl/multi_class_bounded_deque.sv
// Top level of the per-class bounded deque bank: command sequencer, control
// and entry memories. Depends on mcbd_pkg, mcbd_ctrl_mem and mcbd_entry_mem.
//
// A command is taken when start is high and busy is low. Each command gives
// exactly one result, shown for one cycle with done high; the receiver must
// take it then, as there is no way to hold it off. On acceptance the queue's
// head slot and fill count are read from the control memory. In ST_CTRL an
// add or a take that finds an entry updates them and an add or a rejected
// command loads its result; a take that finds an entry also reads the entry
// memory and loads its result in ST_ENTRY. busy stays high from acceptance
// until the cycle in which the result is registered, so the next command may
// start as done rises. No clearing pass is needed after reset.
module multi_class_bounded_deque
	import mcbd_pkg::*;
#(
	parameter int NUM_QUEUES = NUM_QUEUES_DEF,
	parameter int DEPTH      = DEPTH_DEF,
	parameter int TAG_BITS   = TAG_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [3:0]  queue_index,
	input  logic [15:0] entry_tag,
	output logic        done,
	output logic [1:0]  result_code,
	output logic [15:0] taken_tag,
	output logic        taken_urgent,
	output logic [3:0]  fill_after
);

	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);
	localparam int AW = (NUM_QUEUES * DEPTH > 1) ? $clog2(NUM_QUEUES * DEPTH) : 1;
	localparam logic [PW-1:0] HEAD_LAST = PW'(DEPTH - 1);
	localparam logic [PW:0]   DEPTH_W   = (PW+1)'(DEPTH);

	mcbd_state_t state_q, state_d;

	// Command registers
	logic [1:0]          cmd_q;
	logic [3:0]          qidx_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [3:0]          fill_keep_q;

	// Result registers
	logic                done_q;
	logic [1:0]          code_q;
	logic [15:0]         out_tag_q;
	logic                out_urg_q;
	logic [3:0]          out_fill_q;

	// Memory ports
	logic                accept;
	logic [PW-1:0]       cur_head;
	logic [FW-1:0]       cur_fill;
	logic                ctrl_we;
	logic [PW-1:0]       new_head;
	logic [FW-1:0]       new_fill;
	logic                ent_we, ent_re;
	logic [AW-1:0]       ent_addr;
	logic                ent_wurg;
	logic [TAG_BITS-1:0] rd_tag;
	logic                rd_urg;

	// Decode helpers
	logic                in_range, is_take, full, empty;
	logic [QW-1:0]       qa;
	logic [PW-1:0]       head_dec, head_inc, tail_pos;
	logic [PW:0]         tail_sum;
	logic [AW-1:0]       slot_base;

	// Result load from the sequencer
	logic                res_load;
	logic [1:0]          res_code;
	logic [3:0]          res_fill;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	mcbd_ctrl_mem #(
		.NUM_QUEUES (NUM_QUEUES),
		.DEPTH      (DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (QW'(queue_index)),
		.rd_head (cur_head),
		.rd_fill (cur_fill),
		.wr_en   (ctrl_we),
		.wr_addr (qa),
		.wr_head (new_head),
		.wr_fill (new_fill)
	);

	mcbd_entry_mem #(
		.NUM_QUEUES (NUM_QUEUES),
		.DEPTH      (DEPTH),
		.TAG_BITS   (TAG_BITS)
	) u_entry (
		.clk       (clk),
		.wr_en     (ent_we),
		.wr_addr   (ent_addr),
		.wr_tag    (tag_q),
		.wr_urgent (ent_wurg),
		.rd_en     (ent_re),
		.rd_addr   (ent_addr),
		.rd_tag    (rd_tag),
		.rd_urgent (rd_urg)
	);

	// Ring arithmetic on the control word just read
	assign in_range  = 32'(qidx_q) < NUM_QUEUES;
	assign is_take   = cmd_q[1];
	assign qa        = QW'(qidx_q);
	assign full      = 32'(cur_fill) >= DEPTH;
	assign empty     = (cur_fill == '0);
	assign head_dec  = (cur_head == '0) ? HEAD_LAST : cur_head - 1'b1;
	assign head_inc  = (cur_head == HEAD_LAST) ? '0 : cur_head + 1'b1;
	assign tail_sum  = (PW+1)'(cur_head) + (PW+1)'(cur_fill);
	assign tail_pos  = (tail_sum >= DEPTH_W) ? PW'(tail_sum - DEPTH_W) : PW'(tail_sum);
	assign slot_base = AW'(32'(qa) * DEPTH);

	// Next state, memory updates and result selection
	always_comb begin
		state_d  = state_q;
		ctrl_we  = 1'b0;
		new_head = cur_head;
		new_fill = cur_fill;
		ent_we   = 1'b0;
		ent_re   = 1'b0;
		ent_wurg = 1'b0;
		ent_addr = slot_base + AW'(cur_head);
		res_load = 1'b0;
		res_code = RES_ADDED;
		res_fill = 4'(cur_fill);
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_CTRL;
				end
			end
			ST_CTRL: begin
				priority if (!in_range) begin
					res_load = 1'b1;
					res_code = is_take ? RES_EMPTY : RES_FULL;
					res_fill = '0;
					state_d  = ST_IDLE;
				end else if (is_take) begin
					if (empty) begin
						res_load = 1'b1;
						res_code = RES_EMPTY;
						state_d  = ST_IDLE;
					end else begin
						ctrl_we  = 1'b1;
						new_head = head_inc;
						new_fill = cur_fill - 1'b1;
						ent_re   = 1'b1;
						state_d  = ST_ENTRY;
					end
				end else if (full) begin
					res_load = 1'b1;
					res_code = RES_FULL;
					state_d  = ST_IDLE;
				end else begin
					ctrl_we  = 1'b1;
					ent_we   = 1'b1;
					new_fill = cur_fill + 1'b1;
					if (cmd_q == CMD_ADD_HEAD) begin
						new_head = head_dec;
						ent_wurg = 1'b1;
						ent_addr = slot_base + AW'(head_dec);
					end else begin
						ent_addr = slot_base + AW'(tail_pos);
					end
					res_load = 1'b1;
					res_code = RES_ADDED;
					res_fill = 4'(cur_fill + 1'b1);
					state_d  = ST_IDLE;
				end
			end
			ST_ENTRY: begin
				res_load = 1'b1;
				res_code = RES_TAKEN;
				res_fill = fill_keep_q;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_load;
		end
	end

	// Command capture and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd;
			qidx_q <= queue_index;
			tag_q  <= TAG_BITS'(entry_tag);
		end
		if (state_q == ST_CTRL) begin
			fill_keep_q <= 4'(new_fill);
		end
		if (res_load) begin
			code_q     <= res_code;
			out_fill_q <= res_fill;
			if (state_q == ST_ENTRY) begin
				out_tag_q <= 16'(rd_tag);
				out_urg_q <= rd_urg;
			end else begin
				out_tag_q <= '0;
				out_urg_q <= 1'b0;
			end
		end
	end

	assign done         = done_q;
	assign result_code  = code_q;
	assign taken_tag    = out_tag_q;
	assign taken_urgent = out_urg_q;
	assign fill_after   = out_fill_q;

	// Checks
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == ST_CTRL || $past(state_q) == ST_ENTRY))
		else $error("result beat without a command in progress");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	a_no_tag_unless_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result_code != RES_TAKEN) |-> (taken_tag == '0 && !taken_urgent))
		else $error("entry data on a result that took nothing");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(fill_after) <= DEPTH))
		else $error("fill count beyond queue depth");

	a_single_mem_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(ent_we && ent_re))
		else $error("entry memory read and written together");

endmodule
